[hdl/abss_pkg.sv]
// Shared types, codes and reset values for the A/B boot slot selector.
package abss_pkg;

  localparam int unsigned SLOT_COUNT = 2;

  // Request codes
  localparam logic [2:0] REQ_SELECT   = 3'd0;
  localparam logic [2:0] REQ_ACTIVATE = 3'd1;
  localparam logic [2:0] REQ_CONFIRM  = 3'd2;
  localparam logic [2:0] REQ_ROLLBACK = 3'd3;
  localparam logic [2:0] REQ_INIT     = 3'd4;

  // Slot status codes
  localparam logic [1:0] ST_EMPTY     = 2'd0;
  localparam logic [1:0] ST_PENDING   = 2'd1;
  localparam logic [1:0] ST_CONFIRMED = 2'd2;
  localparam logic [1:0] ST_INVALID   = 2'd3;

  // Select actions
  localparam logic [1:0] ACT_BOOT_ACTIVE   = 2'd0;
  localparam logic [1:0] ACT_BOOT_FALLBACK = 2'd1;
  localparam logic [1:0] ACT_STAY          = 2'd2;

  // Slot ids
  localparam logic [1:0] SLOT_A = 2'd1;
  localparam logic [1:0] SLOT_B = 2'd2;

  typedef struct packed {
    logic [2:0] req_type;
    logic [1:0] target_slot;
    logic [7:0] max_attempts;
  } req_t;

  typedef struct packed {
    logic       ok;
    logic [1:0] action;
    logic [1:0] boot_slot;
  } rsp_t;

  typedef struct packed {
    logic [1:0]                 active_id;
    logic [1:0]                 fallback_id;
    logic                       stay_flag;
    logic [SLOT_COUNT-1:0][1:0] slot_status;
    logic [SLOT_COUNT-1:0]      rollback_flag;
    logic [SLOT_COUNT-1:0][7:0] attempts_left;
  } slot_state_t;

  function automatic slot_state_t reset_state();
    slot_state_t s;
    s                = '0;
    s.active_id      = SLOT_A;
    s.fallback_id    = SLOT_B;
    s.slot_status[0] = ST_CONFIRMED;
    s.slot_status[1] = ST_EMPTY;
    return s;
  endfunction

endpackage

[hdl/abss_core.sv]
// Decision logic: next slot state and response for one request.
module abss_core (
  input  abss_pkg::req_t        req,
  input  abss_pkg::slot_state_t cur,
  output abss_pkg::slot_state_t nxt,
  output abss_pkg::rsp_t        rsp
);
  import abss_pkg::*;

  logic       a_ok;
  logic       a_i;
  logic       f_ok;
  logic       f_i;
  logic       t_ok;
  logic       t_i;
  logic       rb;
  logic [1:0] old_active;

  // Ids 1 and 2 name records 0 and 1; 0 and 3 name nothing
  assign a_ok = cur.active_id[1] ^ cur.active_id[0];
  assign a_i  = cur.active_id[1];
  assign f_ok = cur.fallback_id[1] ^ cur.fallback_id[0];
  assign f_i  = cur.fallback_id[1];
  assign t_ok = req.target_slot[1] ^ req.target_slot[0];
  assign t_i  = req.target_slot[1];

  always_comb begin
    nxt        = cur;
    rsp        = '0;
    rb         = 1'b0;
    old_active = cur.active_id;
    unique case (req.req_type)
      REQ_SELECT: begin
        rsp.ok = 1'b1;
        if (cur.stay_flag || !a_ok) begin
          rsp.action = ACT_STAY;
        end else begin
          rb = cur.rollback_flag[a_i];
          // Trial used up: force the rollback path
          if (cur.slot_status[a_i] == ST_PENDING && cur.attempts_left[a_i] == 8'd0) begin
            rb = 1'b1;
          end
          nxt.rollback_flag[a_i] = rb;
          if (rb) begin
            if (f_ok && cur.slot_status[f_i] == ST_CONFIRMED) begin
              rsp.boot_slot          = cur.fallback_id;
              rsp.action             = ACT_BOOT_FALLBACK;
              nxt.active_id          = cur.fallback_id;
              nxt.fallback_id        = old_active;
              nxt.slot_status[a_i]   = ST_INVALID;
              nxt.rollback_flag[a_i] = 1'b0;
            end else begin
              nxt.stay_flag = 1'b1;
              rsp.action    = ACT_STAY;
            end
          end else if (cur.slot_status[a_i] == ST_PENDING) begin
            nxt.attempts_left[a_i] = cur.attempts_left[a_i] - 8'd1;
            rsp.boot_slot          = cur.active_id;
            rsp.action             = ACT_BOOT_ACTIVE;
          end else if (cur.slot_status[a_i] == ST_CONFIRMED) begin
            rsp.boot_slot = cur.active_id;
            rsp.action    = ACT_BOOT_ACTIVE;
          end else if (f_ok && cur.slot_status[f_i] == ST_CONFIRMED) begin
            rsp.boot_slot = cur.fallback_id;
            rsp.action    = ACT_BOOT_FALLBACK;
          end else begin
            nxt.stay_flag = 1'b1;
            rsp.action    = ACT_STAY;
          end
        end
      end
      REQ_ACTIVATE: begin
        if (req.max_attempts != 8'd0 && t_ok) begin
          nxt.slot_status[t_i]   = ST_PENDING;
          nxt.rollback_flag[t_i] = 1'b0;
          nxt.attempts_left[t_i] = req.max_attempts;
          nxt.fallback_id        = cur.active_id;
          nxt.active_id          = req.target_slot;
          nxt.stay_flag          = 1'b0;
          rsp.ok                 = 1'b1;
        end
      end
      REQ_CONFIRM: begin
        if (a_ok) begin
          nxt.slot_status[a_i]   = ST_CONFIRMED;
          nxt.rollback_flag[a_i] = 1'b0;
          nxt.attempts_left[a_i] = 8'd0;
          rsp.ok                 = 1'b1;
        end
      end
      REQ_ROLLBACK: begin
        if (a_ok) begin
          nxt.rollback_flag[a_i] = 1'b1;
          rsp.ok                 = 1'b1;
        end
      end
      REQ_INIT: begin
        nxt             = '0;
        nxt.active_id   = req.target_slot;
        nxt.fallback_id = (req.target_slot == SLOT_A) ? SLOT_B : SLOT_A;
        if (t_ok) begin
          nxt.slot_status[t_i] = ST_CONFIRMED;
        end
        rsp.ok = 1'b1;
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

[hdl/ab_boot_slot_selector_top.sv]
// Top level of the A/B boot slot selector: request register, slot state, response register.
//
//  channel | direction | handshake             | payload
//  req     | in        | req_valid / req_ready | abss_pkg::req_t
//  rsp     | out       | rsp_valid / rsp_ready | abss_pkg::rsp_t
//
// One transaction per cycle sustained while rsp_ready holds; an accepted request passes the
// request register, then the decision logic into the response register, before its response is valid.
// Slot state updates in the same cycle the request leaves the request register.
// Reset restores slot A confirmed and active, slot B empty as fallback, and empties both registers.
// A stalled response holds the request register; req_ready drops once that is full too.
module ab_boot_slot_selector_top (
  input  logic           clk,
  input  logic           rst,
  input  abss_pkg::req_t req,
  input  logic           req_valid,
  output logic           req_ready,
  output abss_pkg::rsp_t rsp,
  output logic           rsp_valid,
  input  logic           rsp_ready
);
  import abss_pkg::*;

  req_t        req_q;
  logic        req_full;
  slot_state_t state;
  slot_state_t state_next;
  rsp_t        rsp_next;
  logic        fire;

  assign fire      = req_full && (!rsp_valid || rsp_ready);
  assign req_ready = !req_full || fire;

  abss_core u_core (
    .req (req_q),
    .cur (state),
    .nxt (state_next),
    .rsp (rsp_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      req_full  <= 1'b0;
      rsp_valid <= 1'b0;
      state     <= reset_state();
    end else begin
      if (req_valid && req_ready) begin
        req_full <= 1'b1;
      end else if (fire) begin
        req_full <= 1'b0;
      end
      if (fire) begin
        rsp_valid <= 1'b1;
        state     <= state_next;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      req_q <= req;
    end
    if (fire) begin
      rsp <= rsp_next;
    end
  end

  a_fire_gives_rsp: assert property (@(posedge clk) disable iff (rst)
    fire |=> rsp_valid)
    else $error("processed transaction produced no response");

  a_state_idle_stable: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(state))
    else $error("slot state changed without a transaction");

  a_stay_no_slot: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.action == ACT_STAY |-> rsp.boot_slot == 2'd0)
    else $error("stay response names a boot slot");

  a_stay_from_select: assert property (@(posedge clk) disable iff (rst)
    $rose(state.stay_flag) |-> $past(req_q.req_type) == REQ_SELECT)
    else $error("stay flag set by a request other than select");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !req_full |-> req_ready)
    else $error("request refused with empty request register");

endmodule

[tb/sv/ab_boot_slot_selector_top_tb.sv]
// Self-checking testbench for the A/B boot slot selector: directed and random commands.
module ab_boot_slot_selector_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import abss_pkg::*;

  localparam int unsigned TOTAL_CMDS  = 825;
  localparam int unsigned CALM_TAIL   = 100;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 150;
  localparam int unsigned MAX_REPORTS = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;

  req_t req       = '0;
  logic req_valid = 1'b0;
  logic req_ready;
  rsp_t rsp;
  logic rsp_valid;
  logic rsp_ready = 1'b0;

  ab_boot_slot_selector_top u_top (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predicted slot records and selector state
  logic [1:0] boot_active;
  logic [1:0] boot_fallback;
  logic       boot_stay;
  logic [1:0] slot_st    [SLOT_COUNT];
  logic       slot_rbk   [SLOT_COUNT];
  logic [7:0] slot_tries [SLOT_COUNT];

  req_t        cmd_q[$];
  rsp_t        boot_rsp_q[$];
  int unsigned n_cmds_taken  = 0;
  int unsigned n_faults      = 0;
  int unsigned cyc           = 0;
  int unsigned idle_cyc      = 0;
  int unsigned send_gap      = 0;
  int unsigned recv_gap      = 0;
  int unsigned send_rate     = 0;
  int unsigned recv_rate     = 0;
  int unsigned hold_left     = 0;
  logic        pressure_done = 1'b0;

  function automatic int slot_rec(logic [1:0] id);
    if (id == SLOT_A || id == SLOT_B) return int'(id) - 1;
    return -1;
  endfunction

  function automatic void load_init(logic [1:0] id);
    for (int i = 0; i < SLOT_COUNT; i++) begin
      slot_st[i]    = ST_EMPTY;
      slot_rbk[i]   = 1'b0;
      slot_tries[i] = 8'd0;
    end
    boot_active   = id;
    boot_fallback = (id == SLOT_A) ? SLOT_B : SLOT_A;
    boot_stay     = 1'b0;
    if (id == SLOT_A) slot_st[0] = ST_CONFIRMED;
    else if (id == SLOT_B) slot_st[1] = ST_CONFIRMED;
  endfunction

  // Advance the predicted state by one command and return the response it gives
  function automatic rsp_t next_boot_response(req_t r);
    rsp_t       o;
    int         a;
    int         f;
    int         t;
    logic [1:0] old_active;
    o = '0;
    a = slot_rec(boot_active);
    f = slot_rec(boot_fallback);
    case (r.req_type)
      REQ_SELECT: begin
        o.ok = 1'b1;
        if (boot_stay || a < 0) begin
          o.action = ACT_STAY;
        end else begin
          if (slot_st[a] == ST_PENDING && slot_tries[a] == 8'd0 && !slot_rbk[a])
            slot_rbk[a] = 1'b1;
          if (slot_rbk[a]) begin
            if (f >= 0 && slot_st[f] == ST_CONFIRMED) begin
              o.action      = ACT_BOOT_FALLBACK;
              o.boot_slot   = boot_fallback;
              old_active    = boot_active;
              boot_active   = boot_fallback;
              boot_fallback = old_active;
              // written after the swap so a shared record still ends up invalid
              slot_st[a]    = ST_INVALID;
              slot_rbk[a]   = 1'b0;
            end else begin
              o.action  = ACT_STAY;
              boot_stay = 1'b1;
            end
          end else if (slot_st[a] == ST_PENDING) begin
            slot_tries[a] = slot_tries[a] - 8'd1;
            o.action      = ACT_BOOT_ACTIVE;
            o.boot_slot   = boot_active;
          end else if (slot_st[a] == ST_CONFIRMED) begin
            o.action    = ACT_BOOT_ACTIVE;
            o.boot_slot = boot_active;
          end else if (f >= 0 && slot_st[f] == ST_CONFIRMED) begin
            o.action    = ACT_BOOT_FALLBACK;
            o.boot_slot = boot_fallback;
          end else begin
            o.action  = ACT_STAY;
            boot_stay = 1'b1;
          end
        end
      end
      REQ_ACTIVATE: begin
        t = slot_rec(r.target_slot);
        if (r.max_attempts != 8'd0 && t >= 0) begin
          slot_st[t]    = ST_PENDING;
          slot_rbk[t]   = 1'b0;
          slot_tries[t] = r.max_attempts;
          boot_fallback = boot_active;
          boot_active   = r.target_slot;
          boot_stay     = 1'b0;
          o.ok          = 1'b1;
        end
      end
      REQ_CONFIRM: begin
        if (a >= 0) begin
          slot_st[a]    = ST_CONFIRMED;
          slot_rbk[a]   = 1'b0;
          slot_tries[a] = 8'd0;
          o.ok          = 1'b1;
        end
      end
      REQ_ROLLBACK: begin
        if (a >= 0) begin
          slot_rbk[a] = 1'b1;
          o.ok        = 1'b1;
        end
      end
      REQ_INIT: begin
        load_init(r.target_slot);
        o.ok = 1'b1;
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic void add_cmd(logic [2:0] t, logic [1:0] s, logic [7:0] m);
    req_t r;
    r.req_type     = t;
    r.target_slot  = s;
    r.max_attempts = m;
    cmd_q.push_back(r);
  endfunction

  function automatic int unsigned pick_rate();
    case ($urandom_range(2))
      0:       return 0;
      1:       return 8;
      default: return 30;
    endcase
  endfunction

  function automatic void log_fault(string msg);
    n_faults++;
    if (n_faults <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
  endfunction

  initial begin
    load_init(SLOT_A);

    // directed part
    add_cmd(REQ_SELECT,   2'd0, 8'd0);
    add_cmd(REQ_CONFIRM,  2'd3, 8'hff);
    add_cmd(REQ_ROLLBACK, 2'd0, 8'd0);
    add_cmd(REQ_SELECT,   2'd0, 8'd0);   // rollback with no confirmed fallback: stay
    add_cmd(REQ_SELECT,   2'd0, 8'd0);   // stay flag holds
    add_cmd(REQ_ACTIVATE, 2'd2, 8'd0);   // zero attempts
    add_cmd(REQ_ACTIVATE, 2'd0, 8'd5);   // unknown slot
    add_cmd(REQ_ACTIVATE, 2'd3, 8'hff);
    add_cmd(REQ_ACTIVATE, 2'd2, 8'd1);
    add_cmd(REQ_SELECT,   2'd0, 8'd0);
    add_cmd(REQ_SELECT,   2'd0, 8'd0);   // trial used up: roll back
    add_cmd(REQ_SELECT,   2'd0, 8'd0);
    add_cmd(REQ_INIT,     2'd2, 8'd0);
    add_cmd(REQ_SELECT,   2'd0, 8'd0);
    add_cmd(REQ_ACTIVATE, 2'd2, 8'hff);  // fallback becomes the active slot
    add_cmd(REQ_CONFIRM,  2'd0, 8'd0);
    add_cmd(REQ_ROLLBACK, 2'd0, 8'd0);
    add_cmd(REQ_SELECT,   2'd0, 8'd0);   // shared record ends up invalid
    add_cmd(REQ_INIT,     2'd0, 8'd0);   // unknown id as active
    add_cmd(REQ_SELECT,   2'd0, 8'd0);
    add_cmd(REQ_CONFIRM,  2'd0, 8'd0);
    add_cmd(REQ_ROLLBACK, 2'd0, 8'd0);
    add_cmd(3'd5,         2'd1, 8'h55);  // unused request codes
    add_cmd(3'd6,         2'd2, 8'haa);
    add_cmd(3'd7,         2'd3, 8'hff);
    add_cmd(REQ_INIT,     2'd3, 8'd0);

    // random part: mostly trial sequences, some noise and broken sequences
    while (cmd_q.size() < TOTAL_CMDS) begin
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: begin
          if ($urandom_range(3) == 0)
            add_cmd(REQ_INIT, 2'($urandom_range(1, 2)), 8'($urandom));
          add_cmd(REQ_ACTIVATE, 2'($urandom_range(1, 2)),
                  ($urandom_range(7) == 0) ? 8'($urandom_range(1, 255))
                                           : 8'($urandom_range(1, 4)));
          repeat ($urandom_range(1, 6)) add_cmd(REQ_SELECT, 2'($urandom), 8'($urandom));
          case ($urandom_range(2))
            0:       add_cmd(REQ_CONFIRM,  2'($urandom), 8'($urandom));
            1:       add_cmd(REQ_ROLLBACK, 2'($urandom), 8'($urandom));
            default: ;
          endcase
          repeat ($urandom_range(1, 3)) add_cmd(REQ_SELECT, 2'($urandom), 8'($urandom));
        end
        12, 13, 14, 15, 16: begin
          add_cmd(3'($urandom_range(7)), 2'($urandom), 8'($urandom));
        end
        default: begin
          if ($urandom_range(1) == 0)
            add_cmd(REQ_ACTIVATE, 2'($urandom_range(1, 2)), 8'd0);
          else
            add_cmd(REQ_ACTIVATE, ($urandom_range(1) == 0) ? 2'd0 : 2'd3, 8'($urandom));
          if ($urandom_range(1) == 0) add_cmd(REQ_ROLLBACK, 2'($urandom), 8'($urandom));
          add_cmd(REQ_SELECT, 2'($urandom), 8'($urandom));
        end
      endcase
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (cmd_q.size() != 0 || boot_rsp_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (n_faults == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  always @(posedge clk) cyc <= cyc + 1;

  // Command driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      req       <= '0;
      send_gap  <= 0;
      send_rate <= 0;
    end else begin
      if (cyc[5:0] == 6'd0) send_rate <= pick_rate();
      if (req_valid && req_ready) begin
        boot_rsp_q.push_back(next_boot_response(req));
        void'(cmd_q.pop_front());
        n_cmds_taken <= n_cmds_taken + 1;
      end
      if (!req_valid || req_ready) begin
        if (send_gap != 0) begin
          send_gap  <= send_gap - 1;
          req_valid <= 1'b0;
        end else if (cmd_q.size() == 0) begin
          req_valid <= 1'b0;
        end else if (cmd_q.size() > CALM_TAIL && $urandom_range(99) < send_rate) begin
          send_gap  <= $urandom_range(10);
          req_valid <= 1'b0;
        end else begin
          req_valid <= 1'b1;
          req       <= cmd_q[0];
        end
      end
    end
  end

  // Response acceptor; one long hold-off lets the block back up into its input
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      recv_gap  <= 0;
      recv_rate <= 0;
    end else begin
      if (cyc[5:0] == 6'd0) recv_rate <= pick_rate();
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        rsp_ready <= 1'b0;
      end else if (!pressure_done && n_cmds_taken >= 300) begin
        pressure_done <= 1'b1;
        hold_left     <= HOLD_CYCLES;
        rsp_ready     <= 1'b0;
      end else if (recv_gap != 0) begin
        recv_gap  <= recv_gap - 1;
        rsp_ready <= 1'b0;
      end else if (cmd_q.size() > CALM_TAIL && $urandom_range(99) < recv_rate) begin
        recv_gap  <= $urandom_range(10);
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // Response checker
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (boot_rsp_q.size() == 0) begin
        log_fault($sformatf("unexpected response ok=%0d action=%0d boot_slot=%0d",
                            rsp.ok, rsp.action, rsp.boot_slot));
      end else begin
        want = boot_rsp_q.pop_front();
        if (rsp.ok !== want.ok || rsp.action !== want.action ||
            rsp.boot_slot !== want.boot_slot)
          log_fault($sformatf({"response mismatch: expected ok=%0d action=%0d ",
                               "boot_slot=%0d, got ok=%0d action=%0d boot_slot=%0d"},
                              want.ok, want.action, want.boot_slot,
                              rsp.ok, rsp.action, rsp.boot_slot));
      end
    end
  end

  // Watchdog: end the run if no transaction moves for too long
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_cyc <= 0;
    end else if (idle_cyc == STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cyc <= idle_cyc + 1;
    end
  end

endmodule

[filelist.f]
hdl/abss_pkg.sv
hdl/abss_core.sv
hdl/ab_boot_slot_selector_top.sv
tb/sv/ab_boot_slot_selector_top_tb.sv
